FILE: rtl/bms_pkg.sv
`timescale 1ns / 1ps

package bms_pkg;

  // Fixed field widths of the item and result channels
  localparam int KIND_W       = 2;
  localparam int ITEM_W       = 32;
  localparam int COUNT_OUT_W  = 6;
  localparam int VALUE_MAX_W  = 64;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Operation codes; any other code behaves as a query
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture a new item, restart the scan
    logic scan;     // issue next read, compare previous read
    logic fetch;    // read the last occupied entry
    logic apply;    // write the store and update the count
    logic publish;  // load the result register
  } bms_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;        // entry under compare matches the value
    logic exhausted;  // all occupied entries compared, none matched
    logic is_remove;  // captured item is a remove
  } bms_status_t;

endpackage

FILE: rtl/bms_ctrl.sv
`timescale 1ns / 1ps

module bms_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bms_pkg::bms_status_t status,
  output bms_pkg::bms_cmd_t    cmd
);

  import bms_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_APPLY,
    ST_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // Result register can take a new result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit || status.exhausted) begin
          state_nxt = status.is_remove ? ST_FETCH : ST_APPLY;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/bms_datapath.sv
`timescale 1ns / 1ps

module bms_datapath #(
  parameter int CAPACITY    = bms_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bms_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bms_pkg::bms_cmd_t                 cmd,
  input  logic [bms_pkg::KIND_W-1:0]        in_kind,
  input  logic [bms_pkg::ITEM_W-1:0]        in_item_value,
  output bms_pkg::bms_status_t              status,
  output logic                              out_was_member,
  output logic [bms_pkg::COUNT_OUT_W-1:0]   out_entry_count,
  output logic                              out_dropped_full
);

  import bms_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Entry store: one write port, one registered read port
  logic [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic [VALUE_WIDTH-1:0]  value_r;
  logic [KIND_W-1:0]       kind_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        rd_idx_r;
  logic                    cmp_vld_r;
  logic [IDX_W-1:0]        cmp_idx_r;
  logic [VALUE_WIDTH-1:0]  rd_data_r;
  logic                    found_r;
  logic [IDX_W-1:0]        slot_r;
  logic                    dropped_r;

  logic                    was_member_r;
  logic [COUNT_OUT_W-1:0]  entry_count_r;
  logic                    dropped_full_r;

  logic [VALUE_MAX_W-1:0]  item_ext;
  logic [VALUE_WIDTH-1:0]  item_val;
  logic                    hit;
  logic                    issue;
  logic [CNT_W-1:0]        last_idx;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [VALUE_WIDTH-1:0]  wr_data;
  logic                    ins_ok;
  logic                    is_full;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  // Reduce the incoming value to the stored width
  assign item_ext = {{(VALUE_MAX_W-ITEM_W){1'b0}}, in_item_value};
  assign item_val = item_ext[VALUE_WIDTH-1:0];

  assign hit      = cmp_vld_r && (rd_data_r == value_r);
  assign issue    = cmd.scan && (rd_idx_r < count_r);
  assign last_idx = count_r - CNT_W'(1);
  assign is_full  = (count_r == CAP_CNT);
  assign ins_ok   = !found_r && !is_full;

  assign status.hit       = hit;
  assign status.exhausted = !cmp_vld_r && (rd_idx_r >= count_r);
  assign status.is_remove = (kind_r == KIND_REMOVE);

  // Select the read and write ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_idx_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = value_r;
    if (issue) begin
      rd_en = 1'b1;
    end else if (cmd.fetch && (count_r != '0)) begin
      rd_en   = 1'b1;
      rd_addr = last_idx[IDX_W-1:0];
    end
    if (cmd.apply) begin
      unique case (kind_r)
        KIND_INSERT: begin
          wr_en = ins_ok;
        end
        KIND_REMOVE: begin
          wr_en   = found_r;
          wr_addr = slot_r;
          wr_data = rd_data_r;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Store access
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Scan and count control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        rd_idx_r  <= '0;
        cmp_vld_r <= 1'b0;
        found_r   <= 1'b0;
        dropped_r <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        if (hit) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.apply) begin
        unique case (kind_r)
          KIND_INSERT: begin
            if (ins_ok) begin
              count_r <= count_r + CNT_W'(1);
            end
            dropped_r <= !found_r && is_full;
          end
          KIND_REMOVE: begin
            if (found_r) begin
              count_r <= last_idx;
            end
          end
          default: dropped_r <= 1'b0;
        endcase
      end
    end
  end

  // Item and scan payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= item_val;
      kind_r  <= in_kind;
    end
    if (issue) begin
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
    if (cmd.scan && hit) begin
      slot_r <= cmp_idx_r;
    end
  end

  // Result register; count reported modulo the field width
  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      was_member_r   <= found_r;
      entry_count_r  <= cnt_ext[COUNT_OUT_W-1:0];
      dropped_full_r <= dropped_r;
    end
  end

  assign out_was_member   = was_member_r;
  assign out_entry_count  = entry_count_r;
  assign out_dropped_full = dropped_full_r;

endmodule

FILE: rtl/bounded_membership_set_core.sv
`timescale 1ns / 1ps

// Set of distinct values kept unordered in a CAPACITY-entry store with an
// occupancy count. Each item inserts, removes or looks up one value (kind
// 0, 1, 2; kind 3 acts as a lookup) and yields one result: prior
// membership, count afterwards (modulo 64) and a flag for an insert of an
// absent value that found the store full. The store has one read port and
// the lookup compares one entry per cycle, from slot 0 up to the value or
// through every occupied entry when it is absent; every remove then also
// fetches the last entry. The longest item is thus a remove of an absent
// value from a full store. Input is stalled while an item is in work; a
// finished result waits in its own register, the next item is taken and
// worked meanwhile, and only its own result waits for the register to
// drain.
module bounded_membership_set_core #(
  parameter int CAPACITY    = bms_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bms_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bms_pkg::KIND_W-1:0]      in_kind,
  input  logic [bms_pkg::ITEM_W-1:0]      in_item_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_was_member,
  output logic [bms_pkg::COUNT_OUT_W-1:0] out_entry_count,
  output logic                            out_dropped_full
);

  import bms_pkg::*;

  bms_cmd_t    cmd;
  bms_status_t status;

  // Sequence the scan, fetch, update and result steps
  bms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Store, count and compare logic
  bms_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_kind),
    .in_item_value    (in_item_value),
    .status           (status),
    .out_was_member   (out_was_member),
    .out_entry_count  (out_entry_count),
    .out_dropped_full (out_dropped_full)
  );

endmodule

FILE: rtl/bms_checker.sv
`timescale 1ns / 1ps

module bms_checker #(
  parameter int CAPACITY = bms_pkg::CAPACITY_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_was_member,
  input logic [bms_pkg::COUNT_OUT_W-1:0] out_entry_count,
  input logic                            out_dropped_full
);

  import bms_pkg::*;

  localparam logic [COUNT_OUT_W-1:0] CAP_MOD = COUNT_OUT_W'(CAPACITY % 64);

  // No result right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Block is busy after taking an item
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an item");

  // A dropped insert means an absent value and a full store
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped_full) |-> (!out_was_member && out_entry_count == CAP_MOD))
    else $error("drop flag with present value or non-full count");

  // Stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_was_member)
      && $stable(out_entry_count) && $stable(out_dropped_full)))
    else $error("stalled result changed");

endmodule

bind bounded_membership_set_core bms_checker #(
  .CAPACITY (CAPACITY)
) u_bms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_was_member   (out_was_member),
  .out_entry_count  (out_entry_count),
  .out_dropped_full (out_dropped_full)
);
